/* sv/ocv_pkg.sv */
// Shared types, constants and helpers for the OCV state-of-charge interpolator.
package ocv_pkg;

  localparam int unsigned NumPoints    = 11;
  localparam int unsigned IdxW         = $clog2(NumPoints);
  localparam int unsigned VoltW        = 16;
  localparam int unsigned PointW       = 8;
  localparam int unsigned SocW         = 14;
  localparam int unsigned QuotW        = 10;           // quotient lies in 0..1000
  localparam int unsigned ProdW        = VoltW + QuotW;
  localparam int unsigned CntW         = $clog2(QuotW);
  localparam int unsigned CentiPerStep = 1000;
  localparam int unsigned CentiFull    = 10000;
  localparam int unsigned SocMaxPct    = 100;
  localparam int unsigned RecipTen     = 205;          // 205 / 2048 ~ 1/10 for 0..100
  localparam int unsigned RecipShift   = 11;

  localparam logic CmdEstimate = 1'b0;
  localparam logic CmdWrite    = 1'b1;

  typedef logic [VoltW-1:0] volt_t;

  localparam volt_t OcvReset [NumPoints] = '{
    16'd3300, 16'd3400, 16'd3450, 16'd3500, 16'd3560, 16'd3600,
    16'd3700, 16'd3800, 16'd4000, 16'd4100, 16'd4200
  };

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // latch voltage, restart scan
    logic wr;          // store a table point
    logic scan;        // step to next table point
    logic capture;     // latch gap and span of the bracketing pair
    logic mul;         // gap * 1000, seed divider
    logic div_step;    // one restoring division step
    logic res_zero;
    logic res_full;
    logic res_interp;
    logic out_load;    // move result into output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hit;         // voltage below current table point
    logic idx_zero;
    logic idx_last;
    logic div_last;
  } st_t;

  // point_soc / 10, exact for 0..100.
  function automatic logic [IdxW-1:0] point_index(input logic [PointW-1:0] pct);
    logic [15:0] prod;
    prod = 16'(pct) * 16'(RecipTen);
    return IdxW'(prod >> RecipShift);
  endfunction

endpackage

/* sv/ocv_if.sv */
// Valid/ready channel interfaces for request and result transfers.
interface ocv_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [ocv_pkg::VoltW-1:0]    voltage_mv;
  logic [ocv_pkg::PointW-1:0]   point_soc;

  modport source (output valid, command, voltage_mv, point_soc, input ready);
  modport sink   (input valid, command, voltage_mv, point_soc, output ready);
endinterface

interface ocv_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ocv_pkg::SocW-1:0]     soc_centi;

  modport source (output valid, soc_centi, input ready);
  modport sink   (input valid, soc_centi, output ready);
endinterface

/* sv/ocv_soc_interpolator.sv */
// Top level: OCV table state-of-charge interpolator, controller plus datapath.
// Write transfers complete in the accept cycle; ready stays high, so writes go back to back.
// Estimate path: SCAN runs to the first point above the voltage; at the table ends it goes
// straight to FINISH, else through MUL, the divider and RES before FINISH loads the output register.
// One item at a time; the scan (one point per cycle), the 10-step divider and output back-pressure set the rate.
// Reset (async, active low) loads the default table and empties the output register.
module ocv_soc_interpolator (
  input  logic       clk_i,
  input  logic       rst_ni,
  ocv_req_if.sink    req_i,
  ocv_rsp_if.source  rsp_o
);

  ocv_pkg::cmd_t cmd;
  ocv_pkg::st_t  st;

  // Controller: accepts a request only when idle, drives the datapath step by step:
  // scan for first point above the voltage, multiply the gap by 1000, divide
  // by the span one quotient bit per cycle, then hand the result to the output
  // register. The output register frees the controller to take the next transfer
  // while a result still waits downstream.
  ocv_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (req_i.ready),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .st_i         (st),
    .cmd_o        (cmd)
  );

  // Datapath: 11-entry table in flops, one read port driven by the scan index,
  // 16x10 constant product, restoring divider, result and output registers.
  ocv_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .voltage_i (req_i.voltage_mv),
    .point_i   (req_i.point_soc),
    .st_o      (st),
    .soc_o     (rsp_o.soc_centi)
  );

endmodule

/* sv/ocv_ctrl.sv */
// Sequencing state machine for table writes and SOC estimates.
module ocv_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_command_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  ocv_pkg::st_t   st_i,
  output ocv_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    IDLE, SCAN, MUL, DIV, RES, FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_xfer;

  assign in_ready_o  = (state_q == IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      IDLE: begin
        cmd_o.load = in_xfer;
        cmd_o.wr   = in_xfer && (in_command_i == ocv_pkg::CmdWrite);
      end
      SCAN: begin
        if (st_i.hit) begin
          cmd_o.res_zero = st_i.idx_zero;
          cmd_o.capture  = !st_i.idx_zero;
        end else if (st_i.idx_last) begin
          cmd_o.res_full = 1'b1;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      MUL:    cmd_o.mul        = 1'b1;
      DIV:    cmd_o.div_step   = 1'b1;
      RES:    cmd_o.res_interp = 1'b1;
      FINISH: cmd_o.out_load   = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_xfer && (in_command_i == ocv_pkg::CmdEstimate)) begin
            state_q <= SCAN;
          end
        end
        SCAN: begin
          if (st_i.hit) begin
            state_q <= st_i.idx_zero ? FINISH : MUL;
          end else if (st_i.idx_last) begin
            state_q <= FINISH;
          end
        end
        MUL: state_q <= DIV;
        DIV: begin
          if (st_i.div_last) begin
            state_q <= RES;
          end
        end
        RES: state_q <= FINISH;
        FINISH: begin
          if (cmd_o.out_load) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  // A write transfer never produces a result.
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_command_i == ocv_pkg::CmdWrite) |=> !$rose(out_valid_q))
    else $error("result raised after a table write");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while held");

  // Scanning past the last point ends the search.
  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SCAN && !st_i.hit && st_i.idx_last) |=> (state_q == FINISH))
    else $error("scan ran past the last table point");

endmodule

/* sv/ocv_dp.sv */
// Table storage, bracket search, product and serial divider datapath.
module ocv_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ocv_pkg::cmd_t               cmd_i,
  input  logic [ocv_pkg::VoltW-1:0]   voltage_i,
  input  logic [ocv_pkg::PointW-1:0]  point_i,
  output ocv_pkg::st_t                st_o,
  output logic [ocv_pkg::SocW-1:0]    soc_o
);

  ocv_pkg::volt_t tbl_q [ocv_pkg::NumPoints];

  ocv_pkg::volt_t                 v_q, prev_q, gap_q, span_q, rem_q, hi;
  logic [ocv_pkg::IdxW-1:0]       idx_q;
  logic [ocv_pkg::QuotW-1:0]      nq_q;        // numerator bits shift out, quotient shifts in
  logic [ocv_pkg::CntW-1:0]       cnt_q;
  logic [ocv_pkg::SocW-1:0]       res_q, soc_q;
  logic [ocv_pkg::ProdW-1:0]      prod;
  logic [ocv_pkg::VoltW:0]        trial;
  logic                           ge;

  assign hi    = tbl_q[idx_q];
  assign prod  = ocv_pkg::ProdW'(gap_q) * ocv_pkg::ProdW'(ocv_pkg::CentiPerStep);
  assign trial = {rem_q, nq_q[ocv_pkg::QuotW-1]};
  assign ge    = trial >= {1'b0, span_q};

  assign st_o.hit      = v_q < hi;
  assign st_o.idx_zero = (idx_q == '0);
  assign st_o.idx_last = (idx_q == ocv_pkg::IdxW'(ocv_pkg::NumPoints - 1));
  assign st_o.div_last = (cnt_q == ocv_pkg::CntW'(ocv_pkg::QuotW - 1));
  assign soc_o         = soc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ocv_pkg::NumPoints; k++) begin
        tbl_q[k] <= ocv_pkg::OcvReset[k];
      end
    end else if (cmd_i.wr && (point_i <= ocv_pkg::PointW'(ocv_pkg::SocMaxPct))) begin
      tbl_q[ocv_pkg::point_index(point_i)] <= voltage_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q   <= voltage_i;
      idx_q <= '0;
    end
    if (cmd_i.scan) begin
      prev_q <= hi;
      idx_q  <= idx_q + 1'b1;
    end
    if (cmd_i.capture) begin
      gap_q  <= hi - v_q;
      span_q <= hi - prev_q;
    end
    if (cmd_i.mul) begin
      // gap <= span, so the top bits are already below the divisor
      rem_q <= prod[ocv_pkg::ProdW-1:ocv_pkg::QuotW];
      nq_q  <= prod[ocv_pkg::QuotW-1:0];
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? ocv_pkg::VoltW'(trial - {1'b0, span_q}) : trial[ocv_pkg::VoltW-1:0];
      nq_q  <= {nq_q[ocv_pkg::QuotW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.res_zero) begin
      res_q <= '0;
    end
    if (cmd_i.res_full) begin
      res_q <= ocv_pkg::SocW'(ocv_pkg::CentiFull);
    end
    if (cmd_i.res_interp) begin
      res_q <= ocv_pkg::SocW'(idx_q) * ocv_pkg::SocW'(ocv_pkg::CentiPerStep)
             - ocv_pkg::SocW'(nq_q);
    end
    if (cmd_i.out_load) begin
      soc_q <= res_q;
    end
  end

  // Bracketing pair always gives a nonzero span covering the gap.
  a_span_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> (span_q != '0 && gap_q <= span_q))
    else $error("bad interpolation bracket");

  // Delivered estimate stays within full scale.
  a_soc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (soc_q <= ocv_pkg::SocW'(ocv_pkg::CentiFull)))
    else $error("estimate above full scale");

endmodule

/* tb/ocv_soc_checker.sv */
// Checker for the OCV interpolator: mirrors the table, predicts each estimate, compares results.
module ocv_soc_checker
  import ocv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ocv_req_if          req_i,
  ocv_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned PctPerPoint = 10;

  volt_t           ocv_mirror [NumPoints];
  logic [SocW-1:0] soc_expected_q [$];
  int unsigned     n_fail = 0;

  // First point strictly above the voltage brackets it with the point before.
  function automatic logic [SocW-1:0] soc_from_voltage(input volt_t mv);
    int unsigned span, gap, frac;
    for (int k = 0; k < NumPoints; k++) begin
      if (mv < ocv_mirror[k]) begin
        if (k == 0) return '0;
        span = ocv_mirror[k] - ocv_mirror[k-1];
        gap  = ocv_mirror[k] - mv;
        frac = (gap * CentiPerStep) / span;
        return SocW'(k * CentiPerStep - frac);
      end
    end
    return SocW'(CentiFull);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    n_fail++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SocW-1:0] want;
    if (!rst_ni) begin
      foreach (ocv_mirror[k]) ocv_mirror[k] = OcvReset[k];
      soc_expected_q.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        if (req_i.command == CmdWrite) begin
          // points above 100 % are dropped
          if (req_i.point_soc <= SocMaxPct)
            ocv_mirror[int'(req_i.point_soc) / PctPerPoint] = req_i.voltage_mv;
        end else begin
          soc_expected_q.push_back(soc_from_voltage(req_i.voltage_mv));
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (soc_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result soc_centi=%0d", rsp_i.soc_centi));
        end else begin
          want = soc_expected_q.pop_front();
          if (rsp_i.soc_centi !== want)
            report_mismatch($sformatf("soc_centi got %0d want %0d", rsp_i.soc_centi, want));
        end
      end
    end
    // published with NBA so readers at the same edge see a stable value
    pending_o    <= soc_expected_q.size();
    fail_count_o <= n_fail;
  end

endmodule

/* tb/ocv_soc_interpolator_tb.sv */
// Testbench top for the OCV interpolator: clock, reset, stimulus, stalls and verdict.
module ocv_soc_interpolator_tb;
  import ocv_pkg::*;

  localparam int unsigned ItemTarget   = 850;  // counted items, ignored writes excluded
  localparam int unsigned IdlePct      = 25;   // idle chance per cycle on each side
  localparam int unsigned SettleCycles = 40;   // above the worst estimate latency
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned SegmentLen   = 100;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          steady = 1'b0;   // when set neither side idles
  int unsigned fail_cnt;
  int unsigned pending_cnt;

  ocv_req_if req_if ();
  ocv_rsp_if rsp_if ();

  ocv_soc_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ocv_soc_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop: ~875 items fit in this time many times over.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random back-pressure, none during the steady stretch.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // One request transfer, with random idle cycles ahead of it.
  // valid stays high into the next call unless that call idles first.
  task automatic send_transfer(input logic cmd, input volt_t mv, input logic [PointW-1:0] pct);
    while (!steady && $urandom_range(99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= cmd;
    req_if.voltage_mv <= mv;
    req_if.point_soc  <= pct;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Estimates ignore point_soc; keep it random so its bits still toggle.
  task automatic send_estimate(input volt_t mv);
    send_transfer(CmdEstimate, mv, PointW'($urandom_range(255)));
  endtask

  task automatic load_default_table();
    for (int k = 0; k < NumPoints; k++)
      send_transfer(CmdWrite, OcvReset[k], PointW'(k * 10));
  endtask

  // Stop sending, wait for every outstanding estimate, then let the block settle.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    req_if.valid <= 1'b0;
    @(posedge clk_i);  // pending count is registered
    while (pending_cnt != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned counted;
    int unsigned seg;
    int unsigned pick;
    bit          wild;
    logic [PointW-1:0] pct;
    volt_t       mv;

    counted = 0;
    seg     = 0;
    wild    = 1'b0;

    req_if.valid      <= 1'b0;
    req_if.command    <= CmdEstimate;
    req_if.voltage_mv <= '0;
    req_if.point_soc  <= '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: table ends, exact breakpoints, ignored and unordered writes
    send_estimate(16'd0);        // below point 0
    send_estimate(16'd3299);
    send_estimate(16'd3300);     // exactly on point 0, quotient of 1000
    send_estimate(16'd3455);
    send_estimate(16'd4199);
    send_estimate(16'd4200);     // at last point -> full
    send_estimate(16'hFFFF);
    send_transfer(CmdWrite, 16'hFFFF, 8'd101);  // above 100 %: no effect
    send_transfer(CmdWrite, 16'h0000, 8'd255);  // above 100 %: no effect
    send_estimate(16'd4200);     // still full if the writes were dropped
    send_transfer(CmdWrite, 16'hFFFF, 8'd100);
    send_estimate(16'hFFFE);     // huge span, tiny gap
    send_estimate(16'hFFFF);
    send_transfer(CmdWrite, 16'h0000, 8'd0);
    send_estimate(16'd0);        // zero lower bound
    send_transfer(CmdWrite, 16'd3000, 8'd59);   // index 5, breaks monotonic order
    send_estimate(16'd3580);
    send_estimate(16'd3100);
    send_transfer(CmdWrite, 16'd3300, 8'd9);    // index truncates to 0
    send_transfer(CmdWrite, 16'd3600, 8'd50);
    send_transfer(CmdWrite, 16'd4200, 8'd100);
    send_estimate(16'd3301);

    // ---- random: segments of realistic or wild tables
    while (counted < ItemTarget) begin
      if (counted / SegmentLen != seg) begin
        seg    = counted / SegmentLen;
        steady = (seg == 3);
        if (seg == 5) drain_results();     // full stop mid-run
        if (wild) begin
          load_default_table();
          counted += NumPoints;
        end
        wild = ($urandom_range(2) == 0);
      end

      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(9) == 0) pct = PointW'($urandom_range(255, 101));
        else                        pct = PointW'($urandom_range(100));
        if (wild) mv = volt_t'($urandom);
        else      mv = volt_t'(2950 + (pct / 10) * 130 + $urandom_range(140));
        send_transfer(CmdWrite, mv, pct);
        if (pct <= SocMaxPct) counted++;
      end else begin
        if (wild || $urandom_range(9) == 0) mv = volt_t'($urandom);
        else                                mv = volt_t'($urandom_range(4600, 2900));
        send_estimate(mv);
        counted++;
      end
    end

    drain_results();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* ocv_soc_interpolator.f */
sv/ocv_pkg.sv
sv/ocv_if.sv
sv/ocv_ctrl.sv
sv/ocv_dp.sv
sv/ocv_soc_interpolator.sv
tb/ocv_soc_checker.sv
tb/ocv_soc_interpolator_tb.sv
